[design/dtsp_pkg.sv]
package dtsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        item_kind;
    logic [31:0] payload_word;
    logic [31:0] tex_width;
    logic [31:0] tex_height;
    logic [31:0] mip_levels;
    logic [2:0]  tex_format;
    logic [63:0] chain_bytes;
    logic [2:0]  load_status;
    logic        last_item;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_FLUSH,
    ST_DESC
  } state_e;

  typedef struct packed {
    logic take_byte;
    logic walk_mul;
    logic walk_acc;
    logic load_word;
    logic load_part;
    logic load_desc;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic walk_trig;
    logic walk_last;
    logic emit_word;
    logic partial;
  } stat_t;

  localparam logic [31:0] MagicDds = 32'h2053_4444;
  localparam logic [31:0] FccDxt1  = 32'h3154_5844;
  localparam logic [31:0] FccDxt3  = 32'h3354_5844;
  localparam logic [31:0] FccDxt5  = 32'h3554_5844;
  localparam logic [31:0] FccAti1  = 32'h3149_5441;
  localparam logic [31:0] FccAti2  = 32'h3249_5441;
  localparam logic [31:0] FccDx10  = 32'h3031_5844;
  localparam logic [31:0] HdrSize  = 32'd124;

  localparam logic [31:0] DXGI_BC1      = 32'd71;
  localparam logic [31:0] DXGI_BC2      = 32'd74;
  localparam logic [31:0] DXGI_BC3      = 32'd77;
  localparam logic [31:0] DXGI_BC4      = 32'd80;
  localparam logic [31:0] DXGI_BC5      = 32'd83;
  localparam logic [31:0] DXGI_BC7      = 32'd98;
  localparam logic [31:0] DXGI_BC7_SRGB = 32'd99;

  localparam logic [7:0] HdrEnd  = 8'd128;
  localparam logic [7:0] DxgiEnd = 8'd132;
  localparam logic [7:0] Dx10End = 8'd148;

  localparam logic [2:0] FMT_RGBA8 = 3'd0;
  localparam logic [2:0] FMT_BC1   = 3'd1;
  localparam logic [2:0] FMT_BC2   = 3'd2;
  localparam logic [2:0] FMT_BC3   = 3'd3;
  localparam logic [2:0] FMT_BC4   = 3'd4;
  localparam logic [2:0] FMT_BC5   = 3'd5;
  localparam logic [2:0] FMT_BC7   = 3'd6;

  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_SHORT    = 3'd1;
  localparam logic [2:0] STS_MAGIC    = 3'd2;
  localparam logic [2:0] STS_HEADER   = 3'd3;
  localparam logic [2:0] STS_UNSUPP   = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DESC    = 1'b1;

endpackage

[design/dtsp_ctrl.sv]
module dtsp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           in_last_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  dtsp_pkg::stat_t stat_i,
  output dtsp_pkg::cmd_t  cmd_o
);
  import dtsp_pkg::*;

  state_e state_q, state_d;
  logic   last_q, last_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   loading;

  assign slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    last_d     = last_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          cmd_o.take_byte = 1'b1;
          cmd_o.load_word = stat_i.emit_word;
          last_d = in_last_i;
          if (stat_i.walk_trig) begin
            state_d = ST_MUL;
          end else if (in_last_i) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_MUL: begin
        cmd_o.walk_mul = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.walk_acc = 1'b1;
        if (stat_i.walk_last) begin
          state_d = last_q ? ST_FLUSH : ST_IDLE;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_FLUSH: begin
        // pending partial word goes out ahead of the descriptor
        if (!stat_i.partial) begin
          state_d = ST_DESC;
        end else if (slot_free) begin
          cmd_o.load_part = 1'b1;
          state_d = ST_DESC;
        end
      end
      ST_DESC: begin
        if (slot_free) begin
          cmd_o.load_desc = 1'b1;
          cmd_o.clear = 1'b1;
          last_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign loading = cmd_o.load_word || cmd_o.load_part || cmd_o.load_desc;

  always_comb begin
    out_valid_d = out_valid_q;
    if (loading) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule

[design/dtsp_dp.sv]
module dtsp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dtsp_pkg::in_item_t  in_data_i,
  input  dtsp_pkg::cmd_t      cmd_i,
  output dtsp_pkg::stat_t     stat_o,
  output dtsp_pkg::out_item_t out_data_o
);
  import dtsp_pkg::*;

  logic [7:0]  off_q;
  logic [31:0] asm_q;
  logic [31:0] size_q, height_q, width_q, mips_q, fourcc_q;
  logic        pf_rgb_q, pf_fcc_q, bits_ok_q, r_ok_q, g_ok_q, b_ok_q, a_ok_q;
  logic [2:0]  fmt_q, status_q;
  logic [63:0] chain_q, pe_q;
  logic [31:0] lw_q, lh_q, rem_q;
  logic [63:0] prod_q;
  out_item_t   out_q, out_d;

  logic        hdr_phase, legacy, dx10, pay_ok, lane3;
  logic [1:0]  ins_lane;
  logic [31:0] asm_new;
  logic [4:0]  word_idx;
  logic        trig;
  logic [2:0]  dec_fmt, dec_status;
  logic [7:0]  start;
  logic [31:0] opa, opb;
  logic [32:0] bw_sum, bh_sum;
  logic [30:0] bw, bh;
  logic [63:0] lb, addend;
  logic [64:0] sum;
  logic [1:0]  sh;
  logic        one_by_one;
  logic [2:0]  desc_st;
  logic        desc_dx;
  logic        decided;

  assign hdr_phase = (off_q < HdrEnd) || (chain_q == '0 && off_q < DxgiEnd);
  assign ins_lane  = hdr_phase ? off_q[1:0] : pe_q[1:0];
  assign lane3     = (off_q[1:0] == 2'd3);
  assign word_idx  = off_q[6:2] - 5'd1;
  assign decided   = (status_q == STS_OK) && (chain_q != '0);

  always_comb begin
    asm_new = asm_q;
    for (int i = 0; i < 4; i++) begin
      if (ins_lane == 2'(i)) asm_new[8*i +: 8] = in_data_i.data_byte;
    end
  end

  assign legacy = pf_rgb_q && bits_ok_q && r_ok_q && g_ok_q && b_ok_q && a_ok_q;
  assign dx10   = !legacy && pf_fcc_q && (fourcc_q == FccDx10);
  assign start  = dx10 ? Dx10End : HdrEnd;
  assign pay_ok = (status_q == STS_OK) && !hdr_phase && (chain_q != '0) &&
                  (off_q >= start) && (pe_q < chain_q);

  // magic check, then format decision at the end of the header or of the extended header
  always_comb begin
    trig       = 1'b0;
    dec_fmt    = FMT_RGBA8;
    dec_status = status_q;
    if (status_q == STS_OK && hdr_phase && lane3) begin
      if (off_q == 8'd3) begin
        if (asm_new != MagicDds) dec_status = STS_MAGIC;
      end else if (off_q == HdrEnd - 8'd1) begin
        if (size_q != HdrSize || width_q == '0 || height_q == '0) begin
          dec_status = STS_HEADER;
        end else if (legacy) begin
          trig = 1'b1;
        end else if (!pf_fcc_q) begin
          dec_status = STS_UNSUPP;
        end else begin
          trig = 1'b1;
          case (fourcc_q)
            FccDxt1: dec_fmt = FMT_BC1;
            FccDxt3: dec_fmt = FMT_BC2;
            FccDxt5: dec_fmt = FMT_BC3;
            FccAti1: dec_fmt = FMT_BC4;
            FccAti2: dec_fmt = FMT_BC5;
            FccDx10: trig = 1'b0;
            default: begin
              trig = 1'b0;
              dec_status = STS_UNSUPP;
            end
          endcase
        end
      end else if (off_q >= HdrEnd) begin
        trig = 1'b1;
        case (asm_new)
          DXGI_BC1: dec_fmt = FMT_BC1;
          DXGI_BC2: dec_fmt = FMT_BC2;
          DXGI_BC3: dec_fmt = FMT_BC3;
          DXGI_BC4: dec_fmt = FMT_BC4;
          DXGI_BC5: dec_fmt = FMT_BC5;
          DXGI_BC7, DXGI_BC7_SRGB: dec_fmt = FMT_BC7;
          default: begin
            trig = 1'b0;
            dec_status = STS_UNSUPP;
          end
        endcase
      end
    end
  end

  // level size: block counts or texels, times bytes per unit
  assign bw_sum = {1'b0, lw_q} + 33'd3;
  assign bh_sum = {1'b0, lh_q} + 33'd3;
  assign bw = (bw_sum[32:2] == '0) ? 31'd1 : bw_sum[32:2];
  assign bh = (bh_sum[32:2] == '0) ? 31'd1 : bh_sum[32:2];
  assign opa = (fmt_q == FMT_RGBA8) ? lw_q : {1'b0, bw};
  assign opb = (fmt_q == FMT_RGBA8) ? lh_q : {1'b0, bh};

  always_comb begin
    case (fmt_q)
      FMT_RGBA8:        sh = 2'd2;
      FMT_BC1, FMT_BC4: sh = 2'd3;
      default:          sh = 2'd0;
    endcase
  end

  always_comb begin
    case (sh)
      2'd2:    lb = (prod_q[63:62] != '0) ? '1 : {prod_q[61:0], 2'b0};
      2'd3:    lb = (prod_q[63:61] != '0) ? '1 : {prod_q[60:0], 3'b0};
      default: lb = (prod_q[63:60] != '0) ? '1 : {prod_q[59:0], 4'b0};
    endcase
  end

  assign one_by_one = (lw_q == 32'd1) && (lh_q == 32'd1);

  // at 1x1 every remaining level has the same size
  always_comb begin
    if (one_by_one) begin
      case (sh)
        2'd2:    addend = {30'd0, rem_q, 2'b0};
        2'd3:    addend = {29'd0, rem_q, 3'b0};
        default: addend = {28'd0, rem_q, 4'b0};
      endcase
    end else begin
      addend = lb;
    end
  end

  assign sum = {1'b0, chain_q} + {1'b0, addend};

  assign stat_o.walk_trig = trig;
  assign stat_o.walk_last = one_by_one || (rem_q == 32'd1);
  assign stat_o.emit_word = pay_ok && (pe_q[1:0] == 2'd3);
  assign stat_o.partial   = decided && (pe_q[1:0] != 2'd0);

  function automatic logic [31:0] swz(input logic [31:0] w, input logic [2:0] f);
    if (f == FMT_RGBA8) return {w[31:24], w[7:0], w[15:8], w[23:16]};
    return w;
  endfunction

  // descriptor status
  always_comb begin
    desc_dx = (status_q == STS_OK || status_q == STS_UNSUPP) && (off_q >= HdrEnd) && dx10;
    desc_st = status_q;
    if (off_q < HdrEnd || (desc_dx && off_q < Dx10End)) begin
      desc_st = STS_SHORT;
    end else if (status_q == STS_OK && (chain_q == '0 || pe_q < chain_q)) begin
      desc_st = STS_SHORT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q     <= '0;
      asm_q     <= '0;
      size_q    <= '0;
      height_q  <= '0;
      width_q   <= '0;
      mips_q    <= '0;
      fourcc_q  <= '0;
      pf_rgb_q  <= 1'b0;
      pf_fcc_q  <= 1'b0;
      bits_ok_q <= 1'b0;
      r_ok_q    <= 1'b0;
      g_ok_q    <= 1'b0;
      b_ok_q    <= 1'b0;
      a_ok_q    <= 1'b0;
      fmt_q     <= '0;
      status_q  <= '0;
      chain_q   <= '0;
      pe_q      <= '0;
      lw_q      <= '0;
      lh_q      <= '0;
      rem_q     <= '0;
    end else if (cmd_i.clear) begin
      off_q     <= '0;
      asm_q     <= '0;
      size_q    <= '0;
      height_q  <= '0;
      width_q   <= '0;
      mips_q    <= '0;
      fourcc_q  <= '0;
      pf_rgb_q  <= 1'b0;
      pf_fcc_q  <= 1'b0;
      bits_ok_q <= 1'b0;
      r_ok_q    <= 1'b0;
      g_ok_q    <= 1'b0;
      b_ok_q    <= 1'b0;
      a_ok_q    <= 1'b0;
      fmt_q     <= '0;
      status_q  <= '0;
      chain_q   <= '0;
      pe_q      <= '0;
      lw_q      <= '0;
      lh_q      <= '0;
      rem_q     <= '0;
    end else if (cmd_i.take_byte) begin
      if (off_q != 8'hff) off_q <= off_q + 8'd1;
      status_q <= dec_status;
      if (status_q == STS_OK && hdr_phase) begin
        asm_q <= trig ? 32'd0 : asm_new;
        if (lane3 && off_q != 8'd3 && off_q < HdrEnd) begin
          case (word_idx)
            5'd0:  size_q   <= asm_new;
            5'd2:  height_q <= asm_new;
            5'd3:  width_q  <= asm_new;
            5'd6:  mips_q   <= asm_new;
            5'd19: begin
              pf_rgb_q <= asm_new[6];
              pf_fcc_q <= asm_new[2];
            end
            5'd20: fourcc_q  <= asm_new;
            5'd21: bits_ok_q <= (asm_new == 32'd32);
            5'd22: r_ok_q    <= (asm_new == 32'h00ff_0000);
            5'd23: g_ok_q    <= (asm_new == 32'h0000_ff00);
            5'd24: b_ok_q    <= (asm_new == 32'h0000_00ff);
            5'd25: a_ok_q    <= (asm_new == 32'hff00_0000);
            default: ;
          endcase
        end
        if (trig) begin
          fmt_q   <= dec_fmt;
          lw_q    <= width_q;
          lh_q    <= height_q;
          rem_q   <= (mips_q == '0) ? 32'd1 : mips_q;
          chain_q <= '0;
        end
      end else if (pay_ok) begin
        asm_q <= (pe_q[1:0] == 2'd3) ? 32'd0 : asm_new;
        pe_q  <= pe_q + 64'd1;
      end
    end else if (cmd_i.walk_acc) begin
      chain_q <= sum[64] ? '1 : sum[63:0];
      lw_q    <= (lw_q[31:1] == '0) ? 32'd1 : {1'b0, lw_q[31:1]};
      lh_q    <= (lh_q[31:1] == '0) ? 32'd1 : {1'b0, lh_q[31:1]};
      rem_q   <= rem_q - 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_mul) prod_q <= opa * opb;
  end

  always_comb begin
    out_d = '0;
    if (cmd_i.load_desc) begin
      out_d.item_kind   = KIND_DESC;
      out_d.load_status = desc_st;
      out_d.last_item   = 1'b1;
      if (decided) begin
        out_d.tex_width   = width_q;
        out_d.tex_height  = height_q;
        out_d.mip_levels  = (mips_q == '0) ? 32'd1 : mips_q;
        out_d.tex_format  = fmt_q;
        out_d.chain_bytes = chain_q;
      end
    end else begin
      out_d.item_kind    = KIND_PAYLOAD;
      out_d.payload_word = swz(cmd_i.load_word ? asm_new : asm_q, fmt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_word || cmd_i.load_part || cmd_i.load_desc) out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

[design/dds_texture_stream_parser.sv]
// texture file parser: bytes of one file enter on the in channel, one per request,
// with last_byte set on the final byte of the file.
// the out channel carries 32-bit payload words (first byte in the low bits, argb
// swizzled to rgba for rgba8) and, after the final byte, one descriptor with last_item set.
// a byte is taken per cycle while the output register drains; a byte that yields
// a payload word shows it on the next cycle.
// after the header (byte 127, or byte 131 for an extended header) the mip chain
// size walk runs on a shared 32x32 multiplier, a multiply then an accumulate state
// per level, at most 32 levels (walk stops at 1x1), during which no byte is taken.
// after the final byte: a flush state that also loads a pending partial word, then
// a descriptor state, each loading only into a free output slot; then the next file.
// a stalled receiver holds the output register and the input stops with it.
// reset clears all parse state; the next byte is taken as the start of a file.
module dds_texture_stream_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dtsp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dtsp_pkg::out_item_t out_data_o
);
  import dtsp_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dtsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_last_i   (in_data_i.last_byte),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dtsp_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
